// File: src/ttw_pkg.sv
// shared types, codes and defaults for the translation table walker
package ttw_pkg;

    localparam int PageBitsDef    = 12;
    localparam int TableLevelsDef = 4;
    localparam int StoreWordsDef  = 4096;

    localparam int VaW     = 48;
    localparam int PaW     = 48;
    localparam int DescW   = 64;
    localparam int WidxW   = 12;
    localparam int StatusW = 2;
    localparam int LevelW  = 2;
    localparam int TypeW   = 2;

    localparam int LastLevel = 3;

    localparam logic [TypeW-1:0] DescBlock = 2'b01;
    localparam logic [TypeW-1:0] DescTable = 2'b11;

    typedef enum logic [StatusW-1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_OUTSIDE = 2'd2,
        STS_WRITE   = 2'd3
    } t_status;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_WALK  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_READ,
        WS_HOLD
    } t_walk_state;

endpackage

// File: src/ttw_if.sv
// request, response and configuration channels of the walker
interface ttw_req_if;
    import ttw_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [WidxW-1:0] word_index;
    logic [DescW-1:0] desc_value;
    logic [VaW-1:0]   virt_addr;

    modport source(output valid, cmd, word_index, desc_value, virt_addr, input ready);
    modport sink(input valid, cmd, word_index, desc_value, virt_addr, output ready);
endinterface

interface ttw_rsp_if;
    import ttw_pkg::*;

    logic               valid;
    logic               ready;
    logic [StatusW-1:0] status;
    logic [PaW-1:0]     entry_pa;
    logic [DescW-1:0]   entry_desc;

    modport source(output valid, status, entry_pa, entry_desc, input ready);
    modport sink(input valid, status, entry_pa, entry_desc, output ready);
endinterface

interface ttw_cfg_if;
    import ttw_pkg::*;

    logic           valid;
    logic           ready;
    logic [PaW-1:0] root_table_pa;

    modport source(output valid, root_table_pa, input ready);
    modport sink(input valid, root_table_pa, output ready);
endinterface

// File: src/translation_table_walker.sv
// top level of the translation table walker
//
// i_req carries one request per handshake: a descriptor write (cmd 0,
// word_index, desc_value) or a walk (cmd 1, virt_addr). o_rsp returns one
// response per request: status, entry_pa and entry_desc. i_cfg writes the
// root table address and is always ready; it is to be written only while
// no request is in flight, which the block itself does not enforce.
// A write is stored in the cycle it is accepted and its response goes to
// the output register if free; the block is then ready again, so writes
// run at one per cycle while o_rsp does not stall.
// A walk issues its first descriptor read in the accept cycle and then
// reads one descriptor per cycle through the single read port of the
// descriptor memory, following table descriptors in the cycle their data
// returns. A walk reads at most TableLevels descriptors, or none if its
// first entry is outside the window; the block takes no request meanwhile.
// The output register lets a new request be taken while a response waits;
// if a later response finishes while o_rsp is still stalled, it is parked
// and the block stops taking requests until o_rsp drains.
// Reset clears the control state, the output valid and the root address;
// descriptor memory contents are undefined until written.
module translation_table_walker #(
    parameter int PageBits    = ttw_pkg::PageBitsDef,
    parameter int TableLevels = ttw_pkg::TableLevelsDef,
    parameter int StoreWords  = ttw_pkg::StoreWordsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttw_req_if.sink   i_req,
    ttw_rsp_if.source o_rsp,
    ttw_cfg_if.sink   i_cfg
);
    import ttw_pkg::*;

    localparam int AddrW = $clog2(StoreWords);

    logic [PaW-1:0]   r_root;
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [DescW-1:0] mem_wdata;
    logic             mem_re;
    logic [AddrW-1:0] mem_raddr;
    logic [DescW-1:0] mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg.valid) begin
            r_root <= i_cfg.root_table_pa;
        end
    end

    ttw_walk_ctrl #(
        .PageBits   (PageBits),
        .TableLevels(TableLevels),
        .StoreWords (StoreWords)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_root_table_pa(r_root),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    ttw_desc_mem #(
        .StoreWords(StoreWords)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

// File: src/ttw_desc_mem.sv
// descriptor memory: one write port, one read port with registered data
module ttw_desc_mem #(
    parameter int StoreWords = ttw_pkg::StoreWordsDef
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(StoreWords)-1:0] i_waddr,
    input  logic [ttw_pkg::DescW-1:0]   i_wdata,
    input  logic                        i_re,
    input  logic [$clog2(StoreWords)-1:0] i_raddr,
    output logic [ttw_pkg::DescW-1:0]   o_rdata
);
    import ttw_pkg::*;

    logic [DescW-1:0] mem [StoreWords];
    logic [DescW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ttw_walk_ctrl.sv
// walk sequencer: address generation, descriptor decode and result staging
module ttw_walk_ctrl #(
    parameter int PageBits    = ttw_pkg::PageBitsDef,
    parameter int TableLevels = ttw_pkg::TableLevelsDef,
    parameter int StoreWords  = ttw_pkg::StoreWordsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ttw_pkg::PaW-1:0]       i_root_table_pa,
    ttw_req_if.sink                       i_req,
    ttw_rsp_if.source                     o_rsp,
    output logic                          o_mem_we,
    output logic [$clog2(StoreWords)-1:0] o_mem_waddr,
    output logic [ttw_pkg::DescW-1:0]     o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(StoreWords)-1:0] o_mem_raddr,
    input  logic [ttw_pkg::DescW-1:0]     i_mem_rdata
);
    import ttw_pkg::*;

    localparam int IdxW  = PageBits - 3;
    localparam int AddrW = $clog2(StoreWords);
    localparam int EpaW  = AddrW + 3;
    localparam int ExtW  = IdxW * 5 + 3;
    localparam int SumW  = PaW + 1;

    localparam logic [SumW-1:0]   Window     = SumW'(StoreWords) << 3;
    localparam logic [LevelW-1:0] FirstLevel = LevelW'(4 - TableLevels);
    localparam logic [PaW-1:0]    TableMask  = ~((PaW'(1) << PageBits) - PaW'(1));
    localparam logic [PaW-1:0]    RootMask   = ~PaW'(7);

    t_walk_state       r_state, n_state;
    logic [VaW-1:0]    r_va, n_va;
    logic [LevelW-1:0] r_level, n_level;
    logic [EpaW-1:0]   r_epa, n_epa;

    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [PaW-1:0]    r_out_pa, n_out_pa;
    logic [DescW-1:0]  r_out_desc, n_out_desc;
    t_status           r_hold_status, n_hold_status;
    logic [PaW-1:0]    r_hold_pa, n_hold_pa;
    logic [DescW-1:0]  r_hold_desc, n_hold_desc;

    // address unit: one table index add and window compare
    logic [PaW-1:0]    au_table;
    logic [VaW-1:0]    au_va;
    logic [LevelW-1:0] au_level;
    logic [ExtW-1:0]   va_ext;
    logic [IdxW-1:0]   au_idx;
    logic [SumW-1:0]   au_sum;
    logic              au_outside;

    logic              out_free;
    logic              in_range;
    logic [TypeW-1:0]  desc_type;
    logic              res_fire;
    t_status           res_status;
    logic [PaW-1:0]    res_pa;
    logic [DescW-1:0]  res_desc;

    always_comb begin
        if (r_state == WS_READ) begin
            au_table = i_mem_rdata[PaW-1:0] & TableMask;
            au_va    = r_va;
            au_level = r_level + LevelW'(1);
        end else begin
            au_table = i_root_table_pa & RootMask;
            au_va    = i_req.virt_addr;
            au_level = FirstLevel;
        end
        va_ext = ExtW'(au_va);
        unique case (au_level)
            2'd0: au_idx = va_ext[IdxW*4+3 +: IdxW];
            2'd1: au_idx = va_ext[IdxW*3+3 +: IdxW];
            2'd2: au_idx = va_ext[IdxW*2+3 +: IdxW];
            2'd3: au_idx = va_ext[IdxW+3 +: IdxW];
        endcase
        au_sum     = {1'b0, au_table} + (SumW'(au_idx) << 3);
        au_outside = au_sum >= Window;
    end

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign in_range    = 32'(i_req.word_index) < 32'(StoreWords);
    assign desc_type   = i_mem_rdata[TypeW-1:0];
    assign o_mem_waddr = AddrW'(i_req.word_index);
    assign o_mem_wdata = i_req.desc_value;
    assign o_mem_raddr = au_sum[3 +: AddrW];

    always_comb begin
        n_state     = r_state;
        n_va        = r_va;
        n_level     = r_level;
        n_epa       = r_epa;
        res_fire    = 1'b0;
        res_status  = STS_OK;
        res_pa      = '0;
        res_desc    = '0;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        i_req.ready = 1'b0;

        unique case (r_state)
            WS_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.cmd == CMD_WRITE) begin
                        // out-of-store index stores nothing but still reports
                        o_mem_we   = in_range;
                        res_fire   = 1'b1;
                        res_status = STS_WRITE;
                    end else if (au_outside) begin
                        res_fire   = 1'b1;
                        res_status = STS_OUTSIDE;
                    end else begin
                        o_mem_re = 1'b1;
                        n_va     = i_req.virt_addr;
                        n_level  = FirstLevel;
                        n_epa    = au_sum[EpaW-1:0];
                        n_state  = WS_READ;
                    end
                end
            end
            WS_READ: begin
                priority if (desc_type == DescTable && r_level != LevelW'(LastLevel)) begin
                    // follow the table: next read goes out this cycle unless its entry is outside the window
                    if (au_outside) begin
                        res_fire   = 1'b1;
                        res_status = STS_OUTSIDE;
                    end else begin
                        o_mem_re = 1'b1;
                        n_epa    = au_sum[EpaW-1:0];
                        n_level  = r_level + LevelW'(1);
                    end
                end else if (desc_type == DescTable || desc_type == DescBlock) begin
                    res_fire   = 1'b1;
                    res_status = STS_OK;
                    res_pa     = PaW'(r_epa);
                    res_desc   = i_mem_rdata;
                end else begin
                    res_fire   = 1'b1;
                    res_status = STS_INVALID;
                end
            end
            WS_HOLD: begin
            end
            default: begin
                n_state = WS_IDLE;
            end
        endcase

        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_pa      = r_out_pa;
        n_out_desc    = r_out_desc;
        n_hold_status = r_hold_status;
        n_hold_pa     = r_hold_pa;
        n_hold_desc   = r_hold_desc;

        if (res_fire) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = res_status;
                n_out_pa     = res_pa;
                n_out_desc   = res_desc;
                n_state      = WS_IDLE;
            end else begin
                n_hold_status = res_status;
                n_hold_pa     = res_pa;
                n_hold_desc   = res_desc;
                n_state       = WS_HOLD;
            end
        end

        if (r_state == WS_HOLD && out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = r_hold_status;
            n_out_pa     = r_hold_pa;
            n_out_desc   = r_hold_desc;
            n_state      = WS_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= WS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va          <= n_va;
        r_level       <= n_level;
        r_epa         <= n_epa;
        r_out_status  <= n_out_status;
        r_out_pa      <= n_out_pa;
        r_out_desc    <= n_out_desc;
        r_hold_status <= n_hold_status;
        r_hold_pa     <= n_hold_pa;
        r_hold_desc   <= n_hold_desc;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.entry_pa   = r_out_pa;
    assign o_rsp.entry_desc = r_out_desc;

endmodule

// File: src/ttw_checker.sv
// port-level checks for the walker, bound to the top level
module ttw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_req_cmd,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [ttw_pkg::StatusW-1:0]   i_rsp_status,
    input logic [ttw_pkg::PaW-1:0]       i_rsp_pa,
    input logic [ttw_pkg::DescW-1:0]     i_rsp_desc
);
    import ttw_pkg::*;

    logic req_fire;
    logic rsp_free;

    assign req_fire = i_req_valid && i_req_ready;
    assign rsp_free = !i_rsp_valid || i_rsp_ready;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_pa) && $stable(i_rsp_desc))
        else $error("stalled response changed");

    a_write_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire && i_req_cmd == CMD_WRITE && rsp_free |=>
            i_rsp_valid && i_rsp_status == STS_WRITE && i_rsp_pa == '0 && i_rsp_desc == '0)
        else $error("write request did not respond next cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == STS_INVALID || i_rsp_status == STS_OUTSIDE) |->
            i_rsp_pa == '0 && i_rsp_desc == '0)
        else $error("failed walk reports nonzero entry");

endmodule

bind translation_table_walker ttw_checker u_ttw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_cmd   (i_req.cmd),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_status(o_rsp.status),
    .i_rsp_pa    (o_rsp.entry_pa),
    .i_rsp_desc  (o_rsp.entry_desc)
);

// File: tb/sv/translation_table_walker_test.sv
// self-checking testbench for the translation table walker: directed and random walks
module translation_table_walker_test;
    import ttw_pkg::*;

    localparam int PageBits    = PageBitsDef;
    localparam int TableLevels = TableLevelsDef;
    localparam int StoreWords  = StoreWordsDef;

    localparam int          IdxBits     = PageBits - 3;
    localparam int          PageFieldW  = PaW - PageBits;
    localparam logic [63:0] IdxMask     = (64'd1 << IdxBits) - 64'd1;
    localparam logic [63:0] AddrMask    = 64'hFFFF_FFFF_FFFF & ~((64'd1 << PageBits) - 64'd1);
    localparam logic [63:0] Window      = 64'(StoreWords) * 64'd8;
    localparam int          WindowPages = (StoreWords * 8) >> PageBits;

    localparam logic [TypeW-1:0] DescVoid     = 2'b00;
    localparam logic [TypeW-1:0] DescReserved = 2'b10;

    localparam int MaxReported = 10;
    localparam int LongHold    = 200;

    typedef struct packed {
        t_status          status;
        logic [PaW-1:0]   pa;
        logic [DescW-1:0] desc;
    } t_walk_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttw_req_if req_ch ();
    ttw_rsp_if rsp_ch ();
    ttw_cfg_if cfg_ch ();

    translation_table_walker #(
        .PageBits   (PageBits),
        .TableLevels(TableLevels),
        .StoreWords (StoreWords)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the descriptor memory and root register
    logic [DescW-1:0] desc_mem_model [StoreWords];
    bit               desc_written   [StoreWords];
    logic [PaW-1:0]   root_pa_model = '0;

    t_walk_outcome expected_rsp_q[$];
    int  mismatch_count = 0;
    int  accepted_items = 0;
    bit  no_idle        = 1'b0;
    bit  hold_output    = 1'b0;

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VaW-1:0] rand_va();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VaW-1:0];
    endfunction

    function automatic logic [DescW-1:0] random_descriptor();
        logic [DescW-1:0] d;
        int pick;
        d = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            d[TypeW-1:0] = DescTable;
            d[PaW-1:PageBits] = PageFieldW'($urandom_range(0, WindowPages - 1));
        end else if (pick < 62) begin
            // next table address left random, mostly beyond the window
            d[TypeW-1:0] = DescTable;
        end else if (pick < 82) begin
            d[TypeW-1:0] = DescBlock;
        end else begin
            d[TypeW-1:0] = pick[0] ? DescVoid : DescReserved;
        end
        return d;
    endfunction

    // walks the shadow tables; missing is the first unwritten word the walk would read
    function automatic void trace_walk(input logic [VaW-1:0] va, output int missing,
                                       output t_walk_outcome outcome);
        logic [63:0] tbl_base;
        logic [63:0] entry_pa;
        logic [63:0] word;
        int shift;
        tbl_base = {16'h0, root_pa_model & ~48'h7};
        missing = -1;
        outcome = '{STS_OK, '0, '0};
        for (int lvl = LastLevel + 1 - TableLevels; lvl <= LastLevel; lvl++) begin
            shift = IdxBits * (LastLevel + 1 - lvl) + 3;
            entry_pa = tbl_base + ((64'(va) >> shift) & IdxMask) * 64'd8;
            if (entry_pa >= Window) begin
                outcome = '{STS_OUTSIDE, '0, '0};
                return;
            end
            if (!desc_written[entry_pa >> 3]) begin
                missing = int'(entry_pa >> 3);
                return;
            end
            word = desc_mem_model[entry_pa >> 3];
            if (word[TypeW-1:0] == DescTable) begin
                tbl_base = word & AddrMask;
                outcome = '{STS_OK, entry_pa[PaW-1:0], word};
            end else if (word[TypeW-1:0] == DescBlock) begin
                outcome = '{STS_OK, entry_pa[PaW-1:0], word};
                return;
            end else begin
                outcome = '{STS_INVALID, '0, '0};
                return;
            end
        end
    endfunction

    task automatic send_request(input t_cmd cmd, input logic [WidxW-1:0] widx,
                                input logic [DescW-1:0] value, input logic [VaW-1:0] va);
        int gap;
        int missing;
        t_walk_outcome outcome;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.word_index <= widx;
        req_ch.desc_value <= value;
        req_ch.virt_addr  <= va;
        do @(posedge i_clk); while (!req_ch.ready);
        if (cmd == CMD_WRITE) begin
            if (widx < StoreWords) begin
                desc_mem_model[widx] = value;
                desc_written[widx] = 1'b1;
            end
            outcome = '{STS_WRITE, '0, '0};
        end else begin
            trace_walk(va, missing, outcome);
        end
        expected_rsp_q.push_back(outcome);
        accepted_items++;
    endtask

    task automatic write_word(input logic [WidxW-1:0] widx, input logic [DescW-1:0] value);
        send_request(CMD_WRITE, widx, value, rand_va());
    endtask

    // fills every unwritten word on the walk path before the walk request
    task automatic walk_with_fill(input logic [VaW-1:0] va);
        int missing;
        t_walk_outcome outcome;
        trace_walk(va, missing, outcome);
        while (missing >= 0) begin
            write_word(missing[WidxW-1:0], random_descriptor());
            trace_walk(va, missing, outcome);
        end
        send_request(CMD_WALK, WidxW'($urandom), {$urandom, $urandom}, va);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_root(input logic [PaW-1:0] pa);
        drain_responses();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.root_table_pa <= pa;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        root_pa_model = pa;
    endtask

    task automatic test_directed();
        set_root('0);
        // chain of tables through pages 1, 2, 3 ending in a block at the last level
        write_word(12'd0, 64'hFFFF_0000_0000_1003);
        write_word(12'd512, 64'h0000_0000_0000_2003);
        write_word(12'd1024, 64'h0000_0000_0000_3003);
        write_word(12'd1536, 64'hFFFF_FFFF_FFFF_FFFD);
        walk_with_fill('0);
        // table descriptor at the last level ends the walk
        write_word(12'd1536, 64'h0000_0000_0000_0003);
        walk_with_fill('0);
        write_word(12'd1024, 64'h0000_0000_0000_0001);
        walk_with_fill('0);
        write_word(12'd512, 64'h0);
        walk_with_fill('0);
        write_word(12'd0, 64'hFFFF_FFFF_FFFF_FFFE);
        walk_with_fill('0);
        write_word(12'd0, 64'h0000_FFFF_FFFF_F003);
        walk_with_fill('0);
        // all-ones address loops through the last word of the window
        write_word(12'd511, 64'h0000_0000_0000_7003);
        write_word(12'd4095, 64'hFFFF_0000_0000_7FFF);
        walk_with_fill('1);
        write_word(12'd0, 64'h0000_0000_0000_0001);
        walk_with_fill('0);
    endtask

    task automatic test_config_extremes();
        set_root('1);
        walk_with_fill('0);
        // unaligned root at the top of the window
        set_root(48'h7FFF);
        walk_with_fill('1);
        walk_with_fill('0);
        set_root(48'h7);
        walk_with_fill('0);
    endtask

    task automatic test_random_walks();
        logic [PaW-1:0] root;
        int quota;
        int start;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase % 4 == 1) begin
                root = PaW'($urandom_range(0, int'(Window) - 1));
            end else if (phase % 4 == 3) begin
                root = rand_va();
            end else begin
                root = PaW'($urandom_range(0, WindowPages - 1)) << PageBits;
            end
            set_root(root);
            no_idle = (phase == 2 || phase == 5);
            quota = (phase % 4 == 3) ? 60 : 160;
            start = accepted_items;
            while (accepted_items - start < quota) begin
                if ($urandom_range(0, 99) < 15) begin
                    write_word(WidxW'($urandom), {$urandom, $urandom});
                end else begin
                    walk_with_fill(rand_va());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_root(48'h0000_0000_1000);
        no_idle = 1'b1;
        hold_output = 1'b1;
        repeat (40) walk_with_fill(rand_va());
        no_idle = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (30) walk_with_fill(rand_va());
        drain_responses();
        repeat (30) walk_with_fill(rand_va());
    endtask

    // receiver pacing: random stalls, plus one long hold on request
    initial begin : rsp_pacing
        int stall;
        int run;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                rsp_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                rsp_ch.ready <= 1'b1;
                run = $urandom_range(1, 20);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_walk_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReported)
                    $display("unexpected response: status %0d entry_pa %h entry_desc %h",
                             rsp_ch.status, rsp_ch.entry_pa, rsp_ch.entry_desc);
            end else begin
                want = expected_rsp_q.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.entry_pa !== want.pa ||
                    rsp_ch.entry_desc !== want.desc) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReported)
                        $display({"mismatch: status exp %0d got %0d, entry_pa exp %h got %h,",
                                  " entry_desc exp %h got %h"},
                                 want.status, rsp_ch.status, want.pa, rsp_ch.entry_pa,
                                 want.desc, rsp_ch.entry_desc);
                end
            end
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= CMD_WRITE;
        req_ch.word_index    <= '0;
        req_ch.desc_value    <= '0;
        req_ch.virt_addr     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.root_table_pa <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_walks();

        drain_responses();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : run_limit
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
